>>> sv/ictu_pkg.sv
// Package for the interrupt and cascade timer unit.
// Holds word types, address constants and the controller state encoding; no dependencies.
package ictu_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_RAISE = 2'd3;

    localparam logic [31:0] BIT31    = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] ID_WORD  = 32'h0202_0000;

    localparam logic [11:0] ADDR_PEND1_SET = 12'h040;
    localparam logic [11:0] ADDR_PEND1_CLR = 12'h044;
    localparam logic [11:0] ADDR_MASK1_SET = 12'h048;
    localparam logic [11:0] ADDR_MASK1_CLR = 12'h04C;
    localparam logic [11:0] ADDR_PEND2_SET = 12'h060;
    localparam logic [11:0] ADDR_PEND2_CLR = 12'h064;
    localparam logic [11:0] ADDR_MASK2_SET = 12'h068;
    localparam logic [11:0] ADDR_MASK2_CLR = 12'h06C;
    localparam logic [11:0] ADDR_TCTL_LO   = 12'h200;
    localparam logic [11:0] ADDR_TCTL_LO_C = 12'h204;
    localparam logic [11:0] ADDR_TCTL_HI   = 12'h208;
    localparam logic [11:0] ADDR_TCTL_HI_C = 12'h20C;
    localparam logic [11:0] ADDR_TMR_BASE  = 12'h100;
    localparam logic [11:0] ADDR_ID        = 12'h000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] address;
        logic [31:0] write_data;
        logic [31:0] raise_first;
        logic [31:0] raise_second;
    } in_word_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fiq_request;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_TICK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic tick_first;
        logic tick_step;
        logic finish;
    } ctl_cmd_t;

endpackage

>>> sv/ictu_ctrl.sv
// Controller state machine of the interrupt and cascade timer unit.
// Depends on ictu_pkg; sequences one timer per cycle during a tick.
module ictu_ctrl
    import ictu_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     is_tick,
    output logic     busy,
    output ctl_cmd_t cmd
);

    localparam int IW = $clog2(NUM_TIMERS);

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (is_tick)
                    begin
                        state_next = ST_TICK;
                        idx_next = '0;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = ST_DONE;
            end
            ST_TICK:
            begin
                cmd.tick_step = 1'b1;
                cmd.tick_first = (idx_reg == '0);
                if (idx_reg == IW'(NUM_TIMERS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end

endmodule

>>> sv/ictu_dp.sv
// Datapath of the interrupt and cascade timer unit: registers, bus decode and timer update.
// Depends on ictu_pkg; driven by commands from ictu_ctrl.
module ictu_dp
    import ictu_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in_word,
    input  ctl_cmd_t  cmd,
    output logic      out_valid,
    output out_word_t out_word
);

    localparam int IW = $clog2(NUM_TIMERS);

    in_word_t      req_reg;
    logic [31:0]   pend1_reg, mask1_reg, pend2_reg, mask2_reg;
    logic [31:0]   tctl_lo_reg, tctl_hi_reg;
    logic [31:0]   count_reg [NUM_TIMERS];
    logic [31:0]   reload_reg [NUM_TIMERS];
    logic [IW-1:0] idx_reg;
    logic          carry_reg;
    logic [31:0]   rdata_reg;
    logic          valid_reg;

    logic [31:0]   pend1_next, mask1_next, pend2_next, mask2_next;
    logic [31:0]   tctl_lo_next, tctl_hi_next, rdata_next;
    logic          carry_next;
    logic          wr_timer, wr_reload;
    logic [IW-1:0] slot;
    logic          slot_ok;
    logic [3:0]    flags;
    logic [31:0]   dec_val;
    logic          cur_carry, under;
    logic [3:0]    idx4;
    logic [11:0]   a;
    logic [31:0]   v;
    logic [11:0]   off;

    assign a = req_reg.address;
    assign v = req_reg.write_data;
    assign off = a - ADDR_TMR_BASE;
    assign slot_ok = (a >= ADDR_TMR_BASE)
                   && ({20'd0, a} < 32'(ADDR_TMR_BASE) + 32'(8 * NUM_TIMERS))
                   && (a[1:0] == 2'b00);
    assign slot = off[IW+2:3];

    assign idx4 = 4'(idx_reg);
    assign cur_carry = cmd.tick_first ? 1'b1 : carry_reg;
    assign flags = !idx4[3] ?
                   4'(tctl_lo_reg >> {idx4[2:0], 2'b00}) :
                   4'(tctl_hi_reg >> {idx4[2:0], 2'b00});
    assign dec_val = count_reg[idx_reg] - (flags[2] ? {31'd0, cur_carry} : 32'd1);
    assign under = (dec_val == ALL_ONES);

    always_comb
    begin
        pend1_next = pend1_reg;
        mask1_next = mask1_reg;
        pend2_next = pend2_reg;
        mask2_next = mask2_reg;
        tctl_lo_next = tctl_lo_reg;
        tctl_hi_next = tctl_hi_reg;
        rdata_next = rdata_reg;
        carry_next = carry_reg;
        wr_timer = 1'b0;
        wr_reload = 1'b0;
        if (cmd.exec)
        begin
            rdata_next = '0;
            case (req_reg.mode)
                MODE_WRITE:
                begin
                    case (a)
                        ADDR_PEND1_SET:
                        begin
                            pend1_next = pend1_reg | v;
                            if (pend2_reg != '0) pend1_next = pend1_next | BIT31;
                        end
                        ADDR_PEND1_CLR:
                        begin
                            pend1_next = pend1_reg & ~v;
                            if (pend2_reg == '0) pend1_next = pend1_next & ~BIT31;
                        end
                        ADDR_MASK1_SET: mask1_next = mask1_reg | v;
                        ADDR_MASK1_CLR: mask1_next = (mask1_reg & ~v) | BIT31;
                        ADDR_PEND2_SET:
                        begin
                            pend2_next = pend2_reg | v;
                            if (pend2_next != '0) pend1_next = pend1_reg | BIT31;
                        end
                        ADDR_PEND2_CLR:
                        begin
                            pend2_next = pend2_reg & ~v;
                            if (pend2_next == '0) pend1_next = pend1_reg & ~BIT31;
                        end
                        ADDR_MASK2_SET: mask2_next = mask2_reg | v;
                        ADDR_MASK2_CLR: mask2_next = mask2_reg & ~v;
                        ADDR_TCTL_LO:   tctl_lo_next = tctl_lo_reg | v;
                        ADDR_TCTL_LO_C: tctl_lo_next = tctl_lo_reg & ~v;
                        ADDR_TCTL_HI:   tctl_hi_next = tctl_hi_reg | v;
                        ADDR_TCTL_HI_C: tctl_hi_next = tctl_hi_reg & ~v;
                        default:
                        begin
                            if (slot_ok)
                            begin
                                wr_timer = ~a[2];
                                wr_reload = a[2];
                            end
                        end
                    endcase
                end
                MODE_READ:
                begin
                    if ((a & ~12'h02C) == ADDR_PEND1_SET)
                    begin
                        case (a & ~12'h004)
                            ADDR_PEND1_SET: rdata_next = pend1_reg;
                            ADDR_MASK1_SET: rdata_next = mask1_reg | BIT31;
                            ADDR_PEND2_SET: rdata_next = pend2_reg;
                            ADDR_MASK2_SET: rdata_next = mask2_reg;
                            default:        rdata_next = '0;
                        endcase
                    end
                    else if (a == ADDR_TCTL_LO || a == ADDR_TCTL_LO_C)
                        rdata_next = tctl_lo_reg;
                    else if (a == ADDR_TCTL_HI || a == ADDR_TCTL_HI_C)
                        rdata_next = tctl_hi_reg;
                    else if (a == ADDR_ID)
                        rdata_next = ID_WORD;
                    else if (slot_ok)
                        rdata_next = a[2] ? reload_reg[slot] : count_reg[slot];
                end
                MODE_TICK: rdata_next = '0;
                default:
                begin
                    pend1_next = pend1_reg | req_reg.raise_first;
                    pend2_next = pend2_reg | req_reg.raise_second;
                    if (pend2_next != '0) pend1_next = pend1_next | BIT31;
                end
            endcase
        end
        if (cmd.tick_step)
        begin
            rdata_next = '0;
            carry_next = cur_carry;
            if (flags[0])
            begin
                carry_next = under;
                if (under)
                begin
                    if (idx4[0])
                    begin
                        pend1_next = pend1_reg | (32'd1 << (5'd10 - 5'(idx4[3:1])));
                        if (pend2_reg != '0) pend1_next = pend1_next | BIT31;
                    end
                    if (!flags[1])
                    begin
                        if (!idx4[3])
                            tctl_lo_next = tctl_lo_reg & ~(32'd1 << {idx4[2:0], 2'b00});
                        else
                            tctl_hi_next = tctl_hi_reg & ~(32'd1 << {idx4[2:0], 2'b00});
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend1_reg <= '0;
            mask1_reg <= '0;
            pend2_reg <= '0;
            mask2_reg <= '0;
            tctl_lo_reg <= '0;
            tctl_hi_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i] <= '0;
                reload_reg[i] <= '0;
            end
            idx_reg <= '0;
            carry_reg <= 1'b1;
            valid_reg <= 1'b0;
            rdata_reg <= '0;
        end
        else
        begin
            pend1_reg <= pend1_next;
            mask1_reg <= mask1_next;
            pend2_reg <= pend2_next;
            mask2_reg <= mask2_next;
            tctl_lo_reg <= tctl_lo_next;
            tctl_hi_reg <= tctl_hi_next;
            carry_reg <= carry_next;
            rdata_reg <= rdata_next;
            valid_reg <= cmd.finish;
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.tick_step)
                idx_reg <= idx_reg + 1'b1;
            if (wr_timer)
                count_reg[slot] <= v;
            if (wr_reload)
                reload_reg[slot] <= v;
            if (cmd.tick_step && flags[0])
                count_reg[idx_reg] <= (under && flags[1]) ? reload_reg[idx_reg] : dec_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= in_word;
    end

    assign out_valid = valid_reg;
    assign out_word.read_data = rdata_reg;
    assign out_word.fiq_request = ((pend1_reg & mask1_reg) != '0)
                                || ((pend2_reg & mask2_reg) != '0);

endmodule

>>> sv/interrupt_and_cascade_timer_unit_core.sv
// Top level of the interrupt and cascade timer unit.
// Depends on ictu_pkg, ictu_ctrl and ictu_dp.
//
// A bus write, bus read or raise runs the execute state and then the finish state
// before the result strobe; a tick runs the tick state, which visits one timer per
// cycle to run the carry chain, and then the finish state. The result word is shown for
// one cycle with done high and cannot be stalled; busy is low again in that same cycle.
module interrupt_and_cascade_timer_unit_core
    import ictu_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  in_word,
    output logic      done,
    output out_word_t out_word
);

    ctl_cmd_t cmd;

    ictu_ctrl #(.NUM_TIMERS(NUM_TIMERS)) u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_tick (in_word.mode == MODE_TICK),
        .busy    (busy),
        .cmd     (cmd)
    );

    ictu_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .out_valid (done),
        .out_word  (out_word)
    );

endmodule

>>> sim/interrupt_and_cascade_timer_unit_core_test.sv
// Testbench for the interrupt and cascade timer unit core: drives bus writes, reads, ticks
// and raises, and checks every result word against a behavioral predictor of the unit.
// Depends on ictu_pkg and interrupt_and_cascade_timer_unit_core.
`timescale 1ns / 1ps

class ictu_scoreboard;
    localparam int NT = 16;
    logic [31:0] pend1, mask1, pend2, mask2, tctl_lo, tctl_hi;
    logic [31:0] count [NT];
    logic [31:0] reload [NT];
    ictu_pkg::out_word_t expected_words [$];
    int errors;

    function new();
        pend1 = 0; mask1 = 0; pend2 = 0; mask2 = 0; tctl_lo = 0; tctl_hi = 0;
        for (int i = 0; i < NT; i++)
        begin
            count[i] = 0;
            reload[i] = 0;
        end
        errors = 0;
    endfunction

    function void mirror_set();
        if (pend2 != 0)
            pend1 |= ictu_pkg::BIT31;
    endfunction

    function void mirror_clear();
        if (pend2 == 0)
            pend1 &= ~ictu_pkg::BIT31;
    endfunction

    function int timer_slot(logic [11:0] a);
        if (a < ictu_pkg::ADDR_TMR_BASE || a >= ictu_pkg::ADDR_TMR_BASE + 8 * NT || a[1:0] != 0)
            return -1;
        return int'((a - ictu_pkg::ADDR_TMR_BASE) >> 3);
    endfunction

    function void bus_write(logic [11:0] a, logic [31:0] v);
        int t;
        case (a)
            ictu_pkg::ADDR_PEND1_SET: begin pend1 |= v; mirror_set(); end
            ictu_pkg::ADDR_PEND1_CLR: begin pend1 &= ~v; mirror_clear(); end
            ictu_pkg::ADDR_MASK1_SET: mask1 |= v;
            ictu_pkg::ADDR_MASK1_CLR: mask1 = (mask1 & ~v) | ictu_pkg::BIT31;
            ictu_pkg::ADDR_PEND2_SET: begin pend2 |= v; mirror_set(); end
            ictu_pkg::ADDR_PEND2_CLR: begin pend2 &= ~v; mirror_clear(); end
            ictu_pkg::ADDR_MASK2_SET: mask2 |= v;
            ictu_pkg::ADDR_MASK2_CLR: mask2 &= ~v;
            ictu_pkg::ADDR_TCTL_LO:   tctl_lo |= v;
            ictu_pkg::ADDR_TCTL_LO_C: tctl_lo &= ~v;
            ictu_pkg::ADDR_TCTL_HI:   tctl_hi |= v;
            ictu_pkg::ADDR_TCTL_HI_C: tctl_hi &= ~v;
            default:
            begin
                t = timer_slot(a);
                if (t >= 0)
                begin
                    if (a[2])
                        reload[t] = v;
                    else
                        count[t] = v;
                end
            end
        endcase
    endfunction

    function logic [31:0] bus_read(logic [11:0] a);
        int t;
        if ((a & ~12'h02C) == 12'h040)
        begin
            case (a & ~12'h004)
                ictu_pkg::ADDR_PEND1_SET: return pend1;
                ictu_pkg::ADDR_MASK1_SET: return mask1 | ictu_pkg::BIT31;
                ictu_pkg::ADDR_PEND2_SET: return pend2;
                ictu_pkg::ADDR_MASK2_SET: return mask2;
                default: return 0;
            endcase
        end
        if (a == ictu_pkg::ADDR_TCTL_LO || a == ictu_pkg::ADDR_TCTL_LO_C)
            return tctl_lo;
        if (a == ictu_pkg::ADDR_TCTL_HI || a == ictu_pkg::ADDR_TCTL_HI_C)
            return tctl_hi;
        if (a == ictu_pkg::ADDR_ID)
            return ictu_pkg::ID_WORD;
        t = timer_slot(a);
        if (t < 0)
            return 0;
        return a[2] ? reload[t] : count[t];
    endfunction

    function void run_tick();
        logic carry;
        logic [3:0] flags;
        carry = 1;
        for (int t = 0; t < NT; t++)
        begin
            flags = (t < 8) ? tctl_lo[(t % 8) * 4 +: 4] : tctl_hi[(t % 8) * 4 +: 4];
            if (flags[0])
            begin
                count[t] = count[t] - (flags[2] ? 32'(carry) : 32'd1);
                if (count[t] == ictu_pkg::ALL_ONES)
                begin
                    carry = 1;
                    if (t % 2 == 1)
                    begin
                        pend1[10 - t / 2] = 1'b1;
                        mirror_set();
                    end
                    if (flags[1])
                        count[t] = reload[t];
                    else if (t < 8)
                        tctl_lo[(t % 8) * 4] = 1'b0;
                    else
                        tctl_hi[(t % 8) * 4] = 1'b0;
                end
                else
                    carry = 0;
            end
        end
    endfunction

    function void note_input(ictu_pkg::in_word_t w);
        ictu_pkg::out_word_t r;
        r.read_data = 0;
        case (w.mode)
            ictu_pkg::MODE_WRITE: bus_write(w.address, w.write_data);
            ictu_pkg::MODE_READ:  r.read_data = bus_read(w.address);
            ictu_pkg::MODE_TICK:  run_tick();
            default:
            begin
                pend1 |= w.raise_first;
                pend2 |= w.raise_second;
                mirror_set();
            end
        endcase
        r.fiq_request = ((pend1 & mask1) != 0) || ((pend2 & mask2) != 0);
        expected_words.push_back(r);
    endfunction

    task check_result(ictu_pkg::out_word_t got);
        ictu_pkg::out_word_t e;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result word %h", got));
            return;
        end
        e = expected_words.pop_front();
        if (got.read_data !== e.read_data)
            report_mismatch($sformatf("read_data %h, expected %h", got.read_data, e.read_data));
        if (got.fiq_request !== e.fiq_request)
            report_mismatch($sformatf("fiq_request %b, expected %b",
                got.fiq_request, e.fiq_request));
    endtask

    task report_mismatch(string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask
endclass

module interrupt_and_cascade_timer_unit_core_test;
    import ictu_pkg::*;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      start = 0;
    logic      busy;
    in_word_t  in_word = '0;
    logic      done;
    out_word_t out_word;
    bit        quiet_phase = 0;

    ictu_scoreboard board = new();

    interrupt_and_cascade_timer_unit_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_word(in_word), .done(done), .out_word(out_word)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(out_word);
    end

    // Called at a falling edge; returns at the falling edge after the word is accepted.
    task automatic send_word(in_word_t w);
        int gap;
        if (!quiet_phase && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        in_word <= w;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        board.note_input(w);
        @(negedge clk);
    endtask

    function automatic in_word_t make_word(logic [1:0] m, logic [11:0] a, logic [31:0] d,
                                           logic [31:0] r1 = 0, logic [31:0] r2 = 0);
        in_word_t w;
        w.mode = m;
        w.address = a;
        w.write_data = d;
        w.raise_first = r1;
        w.raise_second = r2;
        return w;
    endfunction

    function automatic logic [11:0] pick_address();
        logic [11:0] regs [13] = '{ADDR_PEND1_SET, ADDR_PEND1_CLR, ADDR_MASK1_SET,
            ADDR_MASK1_CLR, ADDR_PEND2_SET, ADDR_PEND2_CLR, ADDR_MASK2_SET, ADDR_MASK2_CLR,
            ADDR_TCTL_LO, ADDR_TCTL_LO_C, ADDR_TCTL_HI, ADDR_TCTL_HI_C, ADDR_ID};
        case ($urandom_range(9))
            0, 1, 2, 3: return regs[$urandom_range(12)];
            4, 5, 6, 7: return ADDR_TMR_BASE + 12'($urandom_range(31) * 4);
            8: return 12'($urandom_range(12'h3F) + 12'h040);
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(5))
            0: return 0;
            1: return ALL_ONES;
            2: return 32'($urandom_range(4));
            3: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        in_word_t w;
        int kind;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        send_word(make_word(MODE_READ, ADDR_ID, 0));
        send_word(make_word(MODE_READ, ADDR_MASK1_CLR, 0));
        send_word(make_word(MODE_WRITE, ADDR_MASK1_SET, ALL_ONES));
        send_word(make_word(MODE_RAISE, 0, 0, 0, 32'h1));
        send_word(make_word(MODE_READ, ADDR_PEND1_SET, 0));
        send_word(make_word(MODE_WRITE, ADDR_PEND1_CLR, BIT31));
        send_word(make_word(MODE_READ, ADDR_PEND1_CLR, 0));
        send_word(make_word(MODE_WRITE, ADDR_PEND2_CLR, ALL_ONES));
        send_word(make_word(MODE_WRITE, ADDR_MASK1_CLR, ALL_ONES));
        send_word(make_word(MODE_READ, ADDR_MASK1_SET, 0));
        send_word(make_word(MODE_WRITE, ADDR_MASK2_SET, ALL_ONES));
        send_word(make_word(MODE_RAISE, 0, 0, ALL_ONES, ALL_ONES));
        send_word(make_word(MODE_WRITE, ADDR_TMR_BASE, 32'd0));
        send_word(make_word(MODE_WRITE, ADDR_TMR_BASE + 12'd12, 32'd5));
        send_word(make_word(MODE_WRITE, ADDR_TMR_BASE + 12'd8, 32'd0));
        send_word(make_word(MODE_WRITE, ADDR_TCTL_LO, 32'h0000_0073));
        send_word(make_word(MODE_TICK, 0, 0));
        send_word(make_word(MODE_TICK, 0, 0));
        send_word(make_word(MODE_READ, ADDR_TCTL_LO_C, 0));
        send_word(make_word(MODE_WRITE, ADDR_TCTL_HI, ALL_ONES));
        send_word(make_word(MODE_TICK, 0, 0));
        send_word(make_word(MODE_READ, ADDR_TMR_BASE + 12'h07C, 0));
        send_word(make_word(MODE_WRITE, 12'h0FFF, ALL_ONES));
        send_word(make_word(MODE_READ, 12'h0041, 0));
        send_word(make_word(MODE_READ, ADDR_PEND1_SET, 0));
        for (int i = 0; i < 1400; i++)
        begin
            if (i == 1200)
                quiet_phase = 1;
            kind = $urandom_range(9);
            if (kind < 4)
                w = make_word(MODE_WRITE, pick_address(), pick_data(), $urandom, $urandom);
            else if (kind < 6)
                w = make_word(MODE_READ, pick_address(), $urandom, $urandom, $urandom);
            else if (kind < 9)
                w = make_word(MODE_TICK, 12'($urandom), $urandom, $urandom, $urandom);
            else
                w = make_word(MODE_RAISE, 12'($urandom), $urandom,
                    $urandom_range(1) ? pick_data() : 0, $urandom_range(1) ? pick_data() : 0);
            send_word(w);
        end
        start <= 1'b0;
        while (board.expected_words.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
